>>> sv/fgbb_pkg.sv
// Shared types, constants and helpers for the foreground bounding box block.
// No dependencies.
`timescale 1ns / 1ps

package fgbb_pkg;

   localparam int MAX_CELL = 1024;
   localparam int CELL_CAP_INT = (MAX_CELL < 1024) ? MAX_CELL : 1024;

   localparam int COORD_W = 10;
   localparam int SIZE_W  = 11;
   localparam int CHAN_W  = 8;
   localparam int CSR_W   = 11;
   localparam int CSR_IDX_W = 3;

   localparam logic [SIZE_W-1:0] CELL_CAP = SIZE_W'(CELL_CAP_INT);

   localparam logic [SIZE_W-1:0]  CELL_WIDTH_RST        = 11'd256;
   localparam logic [SIZE_W-1:0]  CELL_HEIGHT_RST       = 11'd256;
   localparam logic [CHAN_W-1:0]  BACKGROUND_LEVEL_RST  = 8'd240;
   localparam logic [CHAN_W-1:0]  BACKGROUND_SPREAD_RST = 8'd12;
   localparam logic [CHAN_W-1:0]  BOX_PADDING_RST       = 8'd4;

   localparam logic [COORD_W-1:0] LEAST_RST    = '1;
   localparam logic [COORD_W-1:0] GREATEST_RST = '0;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELL_WIDTH        = 3'd0,
      CSR_CELL_HEIGHT       = 3'd1,
      CSR_BACKGROUND_LEVEL  = 3'd2,
      CSR_BACKGROUND_SPREAD = 3'd3,
      CSR_BOX_PADDING       = 3'd4
   } csr_index_type;

   // zero acts as one, anything above the cap acts as the cap
   function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] v);
      logic [SIZE_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = SIZE_W'(1);
      end else if (v > CELL_CAP) begin
         r = CELL_CAP;
      end
      return r;
   endfunction

endpackage

>>> sv/fgbb_span.sv
// Clamps one axis' tracked extremes to the cell and grows them by the padding.
// Depends on fgbb_pkg.
`timescale 1ns / 1ps

module fgbb_span (
   input  logic [fgbb_pkg::COORD_W-1:0] lo,
   input  logic [fgbb_pkg::COORD_W-1:0] hi,
   input  logic [fgbb_pkg::SIZE_W-1:0]  size,
   input  logic [fgbb_pkg::CHAN_W-1:0]  pad,
   output logic [fgbb_pkg::COORD_W-1:0] start,
   output logic [fgbb_pkg::COORD_W-1:0] stop
);
   import fgbb_pkg::*;

   logic [COORD_W-1:0] last;
   logic [COORD_W-1:0] lo_c;
   logic [COORD_W-1:0] hi_c;
   logic [COORD_W-1:0] pad_c;
   logic [SIZE_W-1:0]  grown;

   always_comb begin
      last  = COORD_W'(size - SIZE_W'(1));
      lo_c  = (lo > last) ? last : lo;
      hi_c  = (hi > last) ? last : hi;
      pad_c = COORD_W'(pad);
      start = (lo_c > pad_c) ? (lo_c - pad_c) : '0;
      grown = SIZE_W'(hi_c) + SIZE_W'(pad);
      stop  = (grown > SIZE_W'(last)) ? last : grown[COORD_W-1:0];
   end

endmodule

>>> sv/foreground_bounding_box.sv
// Foreground bounding box: one pixel per clock unless stalled, one box per cell out.
// Depends on fgbb_pkg and fgbb_span.
// Pixels of a cell stream in on req_ (tlast on the cell's last pixel). Each pixel
// is classed as background when its brightest channel reaches background_level and
// its channel spread is within background_spread; the extremes of all other pixels
// are tracked. The last pixel yields one box on rsp_, padded and clamped to the cell,
// or the whole cell with tuser set when nothing was found. One pixel is taken per
// clock unless stalled; a box passes the input register, tracker, clamp and pad,
// and length stages. Stalls on rsp_ only hold back pixels once the box stages fill.
// Write the csr_ port only while no transfer is in flight.
`timescale 1ns / 1ps

module foreground_bounding_box (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pixel_x[9:0], pixel_y[19:10], red[27:20], green[35:28], blue[43:36], zero fill
   input  logic [47:0] req_tdata,
   // cell_end
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // box_left[9:0], box_top[19:10], box_width[30:20], box_height[41:31], zero fill
   output logic [47:0] rsp_tdata,
   // cell_empty
   output logic        rsp_tuser,
   input  logic        csr_write_en,
   input  logic [fgbb_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [fgbb_pkg::CSR_W-1:0]     csr_wdata
);
   import fgbb_pkg::*;

   // configuration
   logic [SIZE_W-1:0] cell_width_ff, cell_height_ff;
   logic [CHAN_W-1:0] bg_level_ff, bg_spread_ff, padding_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cell_width_ff  <= CELL_WIDTH_RST;
         cell_height_ff <= CELL_HEIGHT_RST;
         bg_level_ff    <= BACKGROUND_LEVEL_RST;
         bg_spread_ff   <= BACKGROUND_SPREAD_RST;
         padding_ff     <= BOX_PADDING_RST;
      end else if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_CELL_WIDTH:        cell_width_ff  <= csr_wdata;
            CSR_CELL_HEIGHT:       cell_height_ff <= csr_wdata;
            CSR_BACKGROUND_LEVEL:  bg_level_ff    <= csr_wdata[CHAN_W-1:0];
            CSR_BACKGROUND_SPREAD: bg_spread_ff   <= csr_wdata[CHAN_W-1:0];
            CSR_BOX_PADDING:       padding_ff     <= csr_wdata[CHAN_W-1:0];
            default: ;
         endcase
      end
   end

   logic [SIZE_W-1:0] eff_w, eff_h;
   assign eff_w = eff_size(cell_width_ff);
   assign eff_h = eff_size(cell_height_ff);

   // stage handshakes
   logic v1_ff, v2_ff, v3_ff, v4_ff;
   logic last1_ff;
   logic rdy4, rdy3, rdy2, go1;

   assign rdy4 = !v4_ff || rsp_tready;
   assign rdy3 = !v3_ff || rdy4;
   assign rdy2 = !v2_ff || rdy3;
   assign go1  = v1_ff && (!last1_ff || rdy2);
   assign req_tready = !v1_ff || go1;

   // stage 1: input register
   logic [COORD_W-1:0] px_ff, py_ff;
   logic [CHAN_W-1:0]  red_ff, green_ff, blue_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else if (req_tready) begin
         v1_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         px_ff    <= req_tdata[9:0];
         py_ff    <= req_tdata[19:10];
         red_ff   <= req_tdata[27:20];
         green_ff <= req_tdata[35:28];
         blue_ff  <= req_tdata[43:36];
         last1_ff <= req_tlast;
      end
   end

   // classify and track
   logic [CHAN_W-1:0] ch_max, ch_min, spread;
   logic              foreground;
   logic [COORD_W-1:0] lcol_ff, gcol_ff, lrow_ff, grow_ff;
   logic [COORD_W-1:0] lcol_in, gcol_in, lrow_in, grow_in;
   logic              seen_ff, seen_in;

   always_comb begin
      ch_max = red_ff;
      ch_min = red_ff;
      if (green_ff > ch_max) ch_max = green_ff;
      if (blue_ff > ch_max)  ch_max = blue_ff;
      if (green_ff < ch_min) ch_min = green_ff;
      if (blue_ff < ch_min)  ch_min = blue_ff;
      spread = ch_max - ch_min;
      foreground = !((ch_max >= bg_level_ff) && (spread <= bg_spread_ff));
      lcol_in = lcol_ff;
      gcol_in = gcol_ff;
      lrow_in = lrow_ff;
      grow_in = grow_ff;
      seen_in = seen_ff;
      if (foreground) begin
         if (px_ff < lcol_ff) lcol_in = px_ff;
         if (px_ff > gcol_ff) gcol_in = px_ff;
         if (py_ff < lrow_ff) lrow_in = py_ff;
         if (py_ff > grow_ff) grow_in = py_ff;
         seen_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lcol_ff <= LEAST_RST;
         gcol_ff <= GREATEST_RST;
         lrow_ff <= LEAST_RST;
         grow_ff <= GREATEST_RST;
         seen_ff <= 1'b0;
      end else if (go1) begin
         if (last1_ff) begin
            lcol_ff <= LEAST_RST;
            gcol_ff <= GREATEST_RST;
            lrow_ff <= LEAST_RST;
            grow_ff <= GREATEST_RST;
            seen_ff <= 1'b0;
         end else begin
            lcol_ff <= lcol_in;
            gcol_ff <= gcol_in;
            lrow_ff <= lrow_in;
            grow_ff <= grow_in;
            seen_ff <= seen_in;
         end
      end
   end

   // stage 2: final extremes of a cell
   logic [COORD_W-1:0] lx2_ff, hx2_ff, ly2_ff, hy2_ff;
   logic               seen2_ff;
   logic               load2;

   assign load2 = go1 && last1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else if (rdy2) begin
         v2_ff <= load2;
      end
   end

   always_ff @(posedge clock) begin
      if (load2 && rdy2) begin
         lx2_ff   <= lcol_in;
         hx2_ff   <= gcol_in;
         ly2_ff   <= lrow_in;
         hy2_ff   <= grow_in;
         seen2_ff <= seen_in;
      end
   end

   // stage 3: clamp and pad
   logic [COORD_W-1:0] sx, ex, sy, ey;
   logic [COORD_W-1:0] sx3_ff, ex3_ff, sy3_ff, ey3_ff;
   logic               empty3_ff;

   fgbb_span u_span_x (
      .lo(lx2_ff), .hi(hx2_ff), .size(eff_w), .pad(padding_ff), .start(sx), .stop(ex)
   );

   fgbb_span u_span_y (
      .lo(ly2_ff), .hi(hy2_ff), .size(eff_h), .pad(padding_ff), .start(sy), .stop(ey)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (rdy3) begin
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v2_ff && rdy3) begin
         sx3_ff    <= sx;
         ex3_ff    <= ex;
         sy3_ff    <= sy;
         ey3_ff    <= ey;
         empty3_ff <= !seen2_ff;
      end
   end

   // stage 4: lengths, result register
   logic [COORD_W-1:0] left4_ff, top4_ff;
   logic [SIZE_W-1:0]  width4_ff, height4_ff;
   logic               empty4_ff;
   logic [SIZE_W-1:0]  width_in, height_in;

   assign width_in  = SIZE_W'(ex3_ff) - SIZE_W'(sx3_ff) + SIZE_W'(1);
   assign height_in = SIZE_W'(ey3_ff) - SIZE_W'(sy3_ff) + SIZE_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
      end else if (rdy4) begin
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (v3_ff && rdy4) begin
         empty4_ff <= empty3_ff;
         if (empty3_ff) begin
            left4_ff   <= '0;
            top4_ff    <= '0;
            width4_ff  <= eff_w;
            height4_ff <= eff_h;
         end else begin
            left4_ff   <= sx3_ff;
            top4_ff    <= sy3_ff;
            width4_ff  <= width_in;
            height4_ff <= height_in;
         end
      end
   end

   assign rsp_tvalid = v4_ff;
   assign rsp_tdata  = {6'b0, height4_ff, width4_ff, top4_ff, left4_ff};
   assign rsp_tuser  = empty4_ff;

   a_box_nonzero : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (width4_ff != '0) && (height4_ff != '0))
      else $error("box with zero size");

   a_box_in_cell : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((SIZE_W+1)'(left4_ff) + (SIZE_W+1)'(width4_ff) <= (SIZE_W+1)'(eff_w))
                  && ((SIZE_W+1)'(top4_ff) + (SIZE_W+1)'(height4_ff) <= (SIZE_W+1)'(eff_h)))
      else $error("box leaves the cell");

   a_empty_whole : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser) |-> (left4_ff == '0) && (top4_ff == '0))
      else $error("empty cell box not at origin");

   a_clear_after_last : assert property (@(posedge clock) disable iff (reset)
      load2 |=> !seen_ff && (lcol_ff == LEAST_RST) && (grow_ff == GREATEST_RST))
      else $error("trackers not cleared after cell end");

   a_stall_holds : assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> v1_ff && last1_ff && v2_ff)
      else $error("input stalled without a pending box");

endmodule
